@@ hw/rtl/sbrr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbrr_pkg
// Shared types and constants for the stepper rate ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrr_pkg;

	localparam int NUM_BUTTONS  = 4;
	localparam int PERIOD_WIDTH = 16;
	localparam int FREQ_WIDTH   = 32;

	localparam logic [15:0] FASTEST_RST  = 16'h0100;
	localparam logic [15:0] SLOWEST_RST  = 16'h4000;
	localparam logic [7:0]  RAMP_LEN_RST = 8'd128;
	localparam logic [7:0]  DEBOUNCE_RST = 8'h02;
	localparam logic [7:0]  LONG_RST     = 8'd122;
	localparam logic [15:0] PERIOD_MAX   = 16'hFFFF;

	// mode bits
	localparam int MODE_CW     = 0;
	localparam int MODE_HALF   = 1;
	localparam int MODE_SINGLE = 2;

	localparam logic [3:0] PIN_STEP_MASK = 4'h5;
	localparam logic [3:0] PIN_DIR_MASK  = 4'hA;

	typedef enum logic [2:0] {
		CFG_FASTEST  = 3'd0,
		CFG_SLOWEST  = 3'd1,
		CFG_RAMP_LEN = 3'd2,
		CFG_DEBOUNCE = 3'd3,
		CFG_LONG     = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP,
		ST_RAMP,
		ST_RWAIT,
		ST_BTN,
		ST_MLAUNCH,
		ST_MWAIT,
		ST_S1L,
		ST_S1W,
		ST_S2L,
		ST_S2W,
		ST_S3L,
		ST_S3W,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbrr_div.sv @@
// ----------------------------------------------------------------------------
// sbrr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrr_div #(
	parameter int W = sbrr_pkg::FREQ_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);

	localparam int CW = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] shifted;
	logic       ge;

	always_comb begin
		shifted = {rem_q, quot_q[W-1]};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

	// divisor zero gives all ones, as wanted for the reciprocal
	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/stepper_button_rate_ramp_controller.sv @@
// An expiry passes ST_EXP and then ST_FIN. A scan tick passes ST_RAMP, ST_RWAIT if
// a ramp division runs, ST_BTN, then a launch and a wait state per division, ST_FIN.
// A ramp tick runs one division, a ramp start three, a single-step repeat one;
// all use the shared serial divider (one quotient bit per cycle). One request at a
// time; a finished result sits in an output register. Reset: async, active low,
// to power-up state.
// ----------------------------------------------------------------------------
// stepper_button_rate_ramp_controller
// Button-driven step/dir controller with reciprocal frequency ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_button_rate_ramp_controller #(
	parameter int FREQ_WIDTH = sbrr_pkg::FREQ_WIDTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [3:0]  buttons,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       coil_pins,
	output logic [15:0]      step_period,
	output logic             step_enable,
	output logic             clockwise,
	output logic             half_step,
	output logic             single_step,
	output logic             ramping,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int NB = sbrr_pkg::NUM_BUTTONS;
	localparam logic [FREQ_WIDTH-1:0] FMAX = '1;

	sbrr_pkg::state_t state_q, state_d;

	logic [15:0] fastest_q, slowest_q;
	logic [7:0]  rlen_q, deb_q, lpt_q;
	logic [2:0]  mode_q;
	logic [15:0] target_q, applied_q, fast_now_q, slow_now_q;
	logic        pend_q, en_q, ra_q, lp_q;
	logic [7:0]  rl_q;
	logic [FREQ_WIDTH-1:0] freq_q, inc_q, endf_q;
	logic [7:0]  pc_q [NB];
	logic [3:0]  pins_q, btn_q;
	logic        kind_q;
	logic        out_valid_q;
	logic [3:0]  o_pins_q;
	logic [15:0] o_per_q;
	logic [4:0]  o_flags_q;

	logic                  div_start, div_busy, div_done;
	logic [FREQ_WIDTH-1:0] div_a, div_b, div_q, div_r;
	logic [FREQ_WIDTH-1:0] freq_next;
	logic [15:0]           recip_sat;
	logic                  out_load;

	// button step results
	logic [2:0]  b_m;
	logic [15:0] b_tgt, b_fn, b_sn;
	logic        b_pend, b_en, b_ra, b_lp, b_su, b_nm;
	logic [7:0]  b_rl;
	logic [7:0]  b_pc [NB];

	sbrr_div #(.W(FREQ_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	assign freq_next = freq_q + inc_q;
	assign recip_sat = (div_q > FREQ_WIDTH'(sbrr_pkg::PERIOD_MAX)) ?
		sbrr_pkg::PERIOD_MAX : div_q[15:0];
	assign out_load  = (state_q == sbrr_pkg::ST_FIN) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbrr_pkg::ST_IDLE:
				if (in_valid) state_d = kind ? sbrr_pkg::ST_EXP : sbrr_pkg::ST_RAMP;
			sbrr_pkg::ST_EXP:     state_d = sbrr_pkg::ST_FIN;
			sbrr_pkg::ST_RAMP:
				state_d = (ra_q && rl_q != 8'd0) ? sbrr_pkg::ST_RWAIT : sbrr_pkg::ST_BTN;
			sbrr_pkg::ST_RWAIT:   if (div_done) state_d = sbrr_pkg::ST_BTN;
			sbrr_pkg::ST_BTN: begin
				if (b_nm)      state_d = sbrr_pkg::ST_MLAUNCH;
				else if (b_su) state_d = sbrr_pkg::ST_S1L;
				else           state_d = sbrr_pkg::ST_FIN;
			end
			sbrr_pkg::ST_MLAUNCH: state_d = sbrr_pkg::ST_MWAIT;
			sbrr_pkg::ST_MWAIT:   if (div_done) state_d = sbrr_pkg::ST_FIN;
			sbrr_pkg::ST_S1L:     state_d = sbrr_pkg::ST_S1W;
			sbrr_pkg::ST_S1W:     if (div_done) state_d = sbrr_pkg::ST_S2L;
			sbrr_pkg::ST_S2L:     state_d = sbrr_pkg::ST_S2W;
			sbrr_pkg::ST_S2W:     if (div_done) state_d = sbrr_pkg::ST_S3L;
			sbrr_pkg::ST_S3L:     state_d = sbrr_pkg::ST_S3W;
			sbrr_pkg::ST_S3W:     if (div_done) state_d = sbrr_pkg::ST_FIN;
			sbrr_pkg::ST_FIN:     if (out_load) state_d = sbrr_pkg::ST_IDLE;
			default:              state_d = sbrr_pkg::ST_IDLE;
		endcase
	end

	// divider launch and handshake outputs
	always_comb begin
		div_start = 1'b0;
		div_a     = FMAX;
		div_b     = '0;
		unique case (state_q)
			sbrr_pkg::ST_RAMP: begin
				div_start = ra_q && rl_q != 8'd0;
				div_b     = freq_next;
			end
			sbrr_pkg::ST_MLAUNCH: begin
				div_start = 1'b1;
				div_a     = FREQ_WIDTH'(pc_q[2]);
				div_b     = FREQ_WIDTH'(deb_q);
			end
			sbrr_pkg::ST_S1L: begin
				div_start = 1'b1;
				div_b     = FREQ_WIDTH'(target_q >> 1);
			end
			sbrr_pkg::ST_S2L: begin
				div_start = 1'b1;
				div_b     = FREQ_WIDTH'(target_q);
			end
			sbrr_pkg::ST_S3L: begin
				div_start = 1'b1;
				div_a     = endf_q - freq_q;
				div_b     = FREQ_WIDTH'((rlen_q != 8'd0) ? rlen_q : 8'd1);
			end
			default: ;
		endcase
		in_stall  = state_q != sbrr_pkg::ST_IDLE;
		cfg_ready = 1'b1;
	end

	// button processing for one scan tick
	always_comb begin
		b_m    = mode_q;
		b_tgt  = target_q;
		b_fn   = fast_now_q;
		b_sn   = slow_now_q;
		b_pend = pend_q;
		b_en   = en_q;
		b_ra   = ra_q;
		b_lp   = lp_q;
		b_rl   = rl_q;
		b_su   = 1'b0;
		b_nm   = 1'b0;
		for (int i = 0; i < NB; i++) b_pc[i] = pc_q[i];

		if (btn_q == 4'd0) begin
			if (!b_lp && b_pc[1] >= deb_q) begin
				b_m[sbrr_pkg::MODE_SINGLE] = !b_m[sbrr_pkg::MODE_SINGLE];
				if (!b_m[sbrr_pkg::MODE_SINGLE]) b_en = 1'b1;
			end
			for (int i = 0; i < NB; i++) b_pc[i] = 8'd0;
			b_lp = 1'b0;
		end else begin
			if (btn_q[0]) begin
				if (b_pc[0] < lpt_q) b_pc[0] = b_pc[0] + 8'd1;
				if (b_pc[0] == deb_q) b_m[sbrr_pkg::MODE_CW] = !b_m[sbrr_pkg::MODE_CW];
			end else begin
				b_pc[0] = 8'd0;
			end

			if (btn_q[1]) begin
				if (b_pc[1] < lpt_q) b_pc[1] = b_pc[1] + 8'd1;
				if (b_pc[1] == lpt_q) begin
					b_m[sbrr_pkg::MODE_HALF] = !b_m[sbrr_pkg::MODE_HALF];
					if (b_m[sbrr_pkg::MODE_HALF]) begin
						b_tgt = b_tgt >> 1;
						b_fn  = fastest_q >> 1;
						b_sn  = slowest_q >> 1;
					end else begin
						b_tgt = b_tgt[15] ? sbrr_pkg::PERIOD_MAX : {b_tgt[14:0], 1'b0};
						b_fn  = fastest_q;
						b_sn  = slowest_q;
					end
					b_pend  = 1'b1;
					b_lp    = 1'b1;
					b_pc[1] = 8'd0;
				end
			end else begin
				if (!b_lp && b_pc[1] >= deb_q) begin
					b_m[sbrr_pkg::MODE_SINGLE] = !b_m[sbrr_pkg::MODE_SINGLE];
					if (!b_m[sbrr_pkg::MODE_SINGLE]) b_en = 1'b1;
				end
				b_lp    = 1'b0;
				b_pc[1] = 8'd0;
			end

			if (btn_q[2]) begin
				if (!b_m[sbrr_pkg::MODE_SINGLE]) begin
					if (b_pc[2] < lpt_q) b_pc[2] = b_pc[2] + 8'd1;
					if (b_pc[2] == deb_q) begin
						if (!b_ra && (b_tgt >> 1) >= b_fn) begin
							b_ra = 1'b1;
							b_rl = rlen_q;
							b_su = 1'b1;
						end
						b_en = 1'b1;
					end
				end else begin
					// repeat stepping: remainder from the divider unless debounce is zero
					b_pc[2] = b_pc[2] + 8'd1;
					if (deb_q == 8'd0) begin
						if (b_pc[2] == 8'd0) b_en = 1'b1;
					end else begin
						b_nm = 1'b1;
					end
				end
			end else begin
				b_pc[2] = 8'd0;
			end

			if (btn_q[3]) begin
				if (b_pc[3] < lpt_q) b_pc[3] = b_pc[3] + 8'd1;
				if (b_pc[3] == deb_q) begin
					if (!b_m[sbrr_pkg::MODE_SINGLE] && !b_ra && b_tgt <= (b_sn >> 1)) begin
						b_tgt  = b_tgt[15] ? sbrr_pkg::PERIOD_MAX : {b_tgt[14:0], 1'b0};
						b_pend = 1'b1;
					end
					b_en = 1'b1;
				end
			end else begin
				b_pc[3] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbrr_pkg::ST_IDLE;
			fastest_q   <= sbrr_pkg::FASTEST_RST;
			slowest_q   <= sbrr_pkg::SLOWEST_RST;
			rlen_q      <= sbrr_pkg::RAMP_LEN_RST;
			deb_q       <= sbrr_pkg::DEBOUNCE_RST;
			lpt_q       <= sbrr_pkg::LONG_RST;
			mode_q      <= 3'b001;
			target_q    <= sbrr_pkg::SLOWEST_RST;
			applied_q   <= sbrr_pkg::SLOWEST_RST;
			fast_now_q  <= sbrr_pkg::FASTEST_RST;
			slow_now_q  <= sbrr_pkg::SLOWEST_RST;
			pend_q      <= 1'b0;
			en_q        <= 1'b1;
			ra_q        <= 1'b0;
			lp_q        <= 1'b0;
			rl_q        <= 8'd0;
			freq_q      <= '0;
			inc_q       <= '0;
			for (int i = 0; i < NB; i++) pc_q[i] <= 8'd0;
			pins_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					sbrr_pkg::CFG_FASTEST: begin
						fastest_q  <= cfg_data;
						fast_now_q <= mode_q[sbrr_pkg::MODE_HALF] ? (cfg_data >> 1) : cfg_data;
						slow_now_q <= mode_q[sbrr_pkg::MODE_HALF] ? (slowest_q >> 1) : slowest_q;
					end
					sbrr_pkg::CFG_SLOWEST: begin
						slowest_q  <= cfg_data;
						slow_now_q <= mode_q[sbrr_pkg::MODE_HALF] ? (cfg_data >> 1) : cfg_data;
						fast_now_q <= mode_q[sbrr_pkg::MODE_HALF] ? (fastest_q >> 1) : fastest_q;
					end
					sbrr_pkg::CFG_RAMP_LEN: rlen_q <= cfg_data[7:0];
					sbrr_pkg::CFG_DEBOUNCE: deb_q  <= cfg_data[7:0];
					sbrr_pkg::CFG_LONG:     lpt_q  <= cfg_data[7:0];
					default: ;
				endcase
			end

			unique case (state_q)
				sbrr_pkg::ST_EXP: begin
					if (en_q) begin
						if (pend_q) begin
							applied_q <= target_q;
							pend_q    <= 1'b0;
						end
						if (mode_q[1:0] == 2'b00)
							pins_q <= (pins_q ^ sbrr_pkg::PIN_STEP_MASK) | sbrr_pkg::PIN_DIR_MASK;
						else if (mode_q[1:0] == 2'b01)
							pins_q <= (pins_q ^ sbrr_pkg::PIN_STEP_MASK) & sbrr_pkg::PIN_STEP_MASK;
						if (mode_q[sbrr_pkg::MODE_SINGLE]) en_q <= 1'b0;
					end
				end
				sbrr_pkg::ST_RAMP: begin
					if (ra_q) begin
						if (rl_q == 8'd0) begin
							ra_q <= 1'b0;
						end else begin
							rl_q   <= rl_q - 8'd1;
							freq_q <= freq_next;
						end
					end
				end
				sbrr_pkg::ST_RWAIT: begin
					if (div_done) begin
						target_q <= recip_sat;
						pend_q   <= 1'b1;
					end
				end
				sbrr_pkg::ST_BTN: begin
					mode_q     <= b_m;
					target_q   <= b_tgt;
					fast_now_q <= b_fn;
					slow_now_q <= b_sn;
					pend_q     <= b_pend;
					en_q       <= b_en;
					ra_q       <= b_ra;
					lp_q       <= b_lp;
					rl_q       <= b_rl;
					for (int i = 0; i < NB; i++) pc_q[i] <= b_pc[i];
				end
				sbrr_pkg::ST_MWAIT: begin
					if (div_done && div_r == '0) en_q <= 1'b1;
				end
				sbrr_pkg::ST_S2W: begin
					if (div_done) freq_q <= div_q;
				end
				sbrr_pkg::ST_S3W: begin
					if (div_done) inc_q <= div_q;
				end
				default: ;
			endcase

			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sbrr_pkg::ST_IDLE && in_valid) begin
			kind_q <= kind;
			btn_q  <= buttons;
		end
		if (state_q == sbrr_pkg::ST_S1W && div_done) endf_q <= div_q;
		if (out_load) begin
			o_pins_q  <= pins_q;
			o_per_q   <= applied_q;
			o_flags_q <= {ra_q, mode_q[2], mode_q[1], mode_q[0], en_q};
		end
	end

	assign out_valid   = out_valid_q;
	assign coil_pins   = o_pins_q;
	assign step_period = o_per_q;
	assign step_enable = o_flags_q[0];
	assign clockwise   = o_flags_q[1];
	assign half_step   = o_flags_q[2];
	assign single_step = o_flags_q[3];
	assign ramping     = o_flags_q[4];

	// assertions
	a_ramp_left_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ra_q |-> rl_q == 8'd0) else $error("ramp counter left over after ramp end");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbrr_pkg::ST_IDLE |-> !div_busy) else $error("divider busy while idle");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == sbrr_pkg::ST_RWAIT || state_q == sbrr_pkg::ST_MWAIT ||
		state_q == sbrr_pkg::ST_S1W || state_q == sbrr_pkg::ST_S2W ||
		state_q == sbrr_pkg::ST_S3W)) else $error("division finished outside a wait state");

	a_kind_path: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbrr_pkg::ST_EXP |-> kind_q)
		else $error("expiry path entered for a scan tick");

endmodule

`default_nettype wire
